[rtl/sp64_pkg.sv]
package sp64_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] MWC_MUL     = 64'hFFF6_2CF2_CCC0_CDAF;

  // Splitmix rounds run by a seed beat: the discarded warm-up rounds, then four fill rounds.
  localparam logic [7:0] WARM_ROUNDS = 8'd128;
  localparam logic [7:0] ROUND_LAST  = 8'd131;

  // Step index at which a 64x64 product has had all four partial products summed.
  localparam logic [2:0] MUL_STEP_LAST = 3'd4;

  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [1:0] {
    GEN_MIX,
    GEN_PAIR,
    GEN_QUAD,
    GEN_CARRY
  } gen_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_START,
    ST_MIX_A,
    ST_MIX_B,
    ST_MWC,
    ST_OUT
  } state_t;

endpackage

[rtl/sp64_req_if.sv]
interface sp64_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink (input valid, input func, input seed_value, output ready);
endinterface

[rtl/sp64_rsp_if.sv]
interface sp64_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

[rtl/selectable_prng_64_core.sv]
// Channel   Direction  Payload                       Beat
// req       in         func, seed_value              valid && ready
// rsp       out        random_word                   valid && ready
// cfg       in         cfg_wdata (generator select)  cfg_we
//
// One 32x32 multiplier, registered, forms each 64x64 product as four partial
// products summed in turn. A draw for xoroshiro128+ or xoshiro256+ goes from
// idle straight to the result beat; multiply-with-carry first runs one product
// and splitmix64 two. A result is held until rsp is ready. A seed beat runs 132
// splitmix rounds. req is taken only when the previous beat is finished.
// rst is synchronous and clears all generator state to zero and selects xoshiro256+.
module selectable_prng_64_core
  import sp64_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sp64_req_if.sink          req,
  sp64_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);

  state_t        state, state_next;
  gen_t          gen, gen_next;
  logic [63:0]   mix_counter, mix_counter_next;
  logic [63:0]   pair [2];
  logic [63:0]   pair_next [2];
  logic [63:0]   quad [4];
  logic [63:0]   quad_next [4];
  logic [63:0]   carry [4];
  logic [63:0]   carry_next [4];
  logic [63:0]   mul_a, mul_a_next;
  logic [63:0]   mul_b, mul_b_next;
  logic [127:0]  acc, acc_next;
  logic [63:0]   prod, prod_next;
  logic [1:0]    prod_k, prod_k_next;
  logic [2:0]    step, step_next;
  logic [7:0]    round, round_next;
  logic          seeding, seeding_next;
  logic [63:0]   result, result_next;

  logic [31:0]   a_sel, b_sel;
  logic [127:0]  pp_shifted, acc_sum;
  logic [63:0]   cnt_inc, mix_z, mix_out;
  logic [63:0]   pair_res, pair_x;
  logic [63:0]   quad_res, quad_t, quad_2a, quad_3a;
  logic [1:0]    fill_idx;
  logic          mul_done;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = (state == ST_OUT);
  assign rsp.random_word = result;

  // Partial product k: bit 1 picks the high half of mul_a, bit 0 the high half of mul_b.
  always_comb begin
    a_sel = step[1] ? mul_a[63:32] : mul_a[31:0];
    b_sel = step[0] ? mul_b[63:32] : mul_b[31:0];
    prod_next = 64'(a_sel) * 64'(b_sel);
    unique case (prod_k)
      2'd0:    pp_shifted = {64'b0, prod};
      2'd3:    pp_shifted = {prod, 64'b0};
      default: pp_shifted = {32'b0, prod, 32'b0};
    endcase
    acc_sum  = acc + pp_shifted;
    mul_done = (step == MUL_STEP_LAST);
  end

  always_comb begin
    cnt_inc  = mix_counter + GOLDEN_STEP;
    mix_z    = acc_sum[63:0];
    mix_out  = mix_z ^ (mix_z >> 31);
    fill_idx = round[1:0];

    pair_res = pair[0] + pair[1];
    pair_x   = pair[1] ^ pair[0];

    quad_res = quad[0] + quad[3];
    quad_t   = quad[1] << 17;
    quad_2a  = quad[2] ^ quad[0];
    quad_3a  = quad[3] ^ quad[1];
  end

  always_comb begin
    state_next       = state;
    gen_next         = cfg_we ? gen_t'(cfg_wdata) : gen;
    mix_counter_next = mix_counter;
    pair_next        = pair;
    quad_next        = quad;
    carry_next       = carry;
    mul_a_next       = mul_a;
    mul_b_next       = mul_b;
    acc_next         = acc;
    prod_k_next      = step[1:0];
    step_next        = step;
    round_next       = round;
    seeding_next     = seeding;
    result_next      = result;

    // The multiplier states share the step count and accumulation.
    if (state == ST_MIX_A || state == ST_MIX_B || state == ST_MWC) begin
      step_next = step + 3'd1;
      if (step != 3'd0) begin
        acc_next = acc_sum;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.func == FUNC_SEED) begin
            mix_counter_next = req.seed_value;
            seeding_next     = 1'b1;
            round_next       = 8'd0;
            state_next       = ST_MIX_START;
          end else begin
            unique case (gen)
              GEN_MIX: begin
                state_next = ST_MIX_START;
              end
              GEN_PAIR: begin
                result_next  = pair_res;
                pair_next[0] = {pair[0][39:0], pair[0][63:40]} ^ pair_x ^ (pair_x << 16);
                pair_next[1] = {pair_x[26:0], pair_x[63:27]};
                state_next   = ST_OUT;
              end
              GEN_QUAD: begin
                result_next  = quad_res;
                quad_next[1] = quad[1] ^ quad_2a;
                quad_next[0] = quad[0] ^ quad_3a;
                quad_next[2] = quad_2a ^ quad_t;
                quad_next[3] = {quad_3a[18:0], quad_3a[63:19]};
                state_next   = ST_OUT;
              end
              GEN_CARRY: begin
                mul_a_next = carry[0];
                mul_b_next = MWC_MUL;
                acc_next   = {64'b0, carry[3]};
                step_next  = 3'd0;
                state_next = ST_MWC;
              end
              default: ;
            endcase
          end
        end
      end

      ST_MIX_START: begin
        mix_counter_next = cnt_inc;
        mul_a_next       = cnt_inc ^ (cnt_inc >> 30);
        mul_b_next       = MIX_MUL_A;
        acc_next         = 128'b0;
        step_next        = 3'd0;
        state_next       = ST_MIX_A;
      end

      ST_MIX_A: begin
        if (mul_done) begin
          mul_a_next = mix_z ^ (mix_z >> 27);
          mul_b_next = MIX_MUL_B;
          acc_next   = 128'b0;
          step_next  = 3'd0;
          state_next = ST_MIX_B;
        end
      end

      ST_MIX_B: begin
        if (mul_done) begin
          step_next = 3'd0;
          if (seeding) begin
            // The last four rounds fill words 0 to 3 of quad and carry, and 0 to 1 of pair.
            if (round >= WARM_ROUNDS) begin
              quad_next[fill_idx]  = mix_out;
              carry_next[fill_idx] = mix_out;
              if (!fill_idx[1]) begin
                pair_next[fill_idx[0]] = mix_out;
              end
            end
            if (round == ROUND_LAST) begin
              seeding_next = 1'b0;
              state_next   = ST_IDLE;
            end else begin
              round_next = round + 8'd1;
              state_next = ST_MIX_START;
            end
          end else begin
            result_next = mix_out;
            state_next  = ST_OUT;
          end
        end
      end

      ST_MWC: begin
        if (mul_done) begin
          step_next     = 3'd0;
          result_next   = carry[2];
          carry_next[0] = carry[1];
          carry_next[1] = carry[2];
          carry_next[2] = acc_sum[63:0];
          carry_next[3] = acc_sum[127:64];
          state_next    = ST_OUT;
        end
      end

      ST_OUT: begin
        if (rsp.ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen         <= GEN_QUAD;
      mix_counter <= 64'b0;
      pair        <= '{default: 64'b0};
      quad        <= '{default: 64'b0};
      carry       <= '{default: 64'b0};
      step        <= 3'd0;
      round       <= 8'd0;
      seeding     <= 1'b0;
    end else begin
      gen         <= gen_next;
      mix_counter <= mix_counter_next;
      pair        <= pair_next;
      quad        <= quad_next;
      carry       <= carry_next;
      step        <= step_next;
      round       <= round_next;
      seeding     <= seeding_next;
    end
  end

  always_ff @(posedge clk) begin
    mul_a  <= mul_a_next;
    mul_b  <= mul_b_next;
    acc    <= acc_next;
    prod   <= prod_next;
    prod_k <= prod_k_next;
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_no_take_while_showing: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken while a result beat is pending");

  a_step_only_in_mul: assert property (@(posedge clk) disable iff (rst)
    (step != 3'd0) |-> (state == ST_MIX_A || state == ST_MIX_B || state == ST_MWC))
    else $error("multiplier step count running outside a multiply");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step <= MUL_STEP_LAST)
    else $error("multiplier step count overran");

  a_seed_no_result: assert property (@(posedge clk) disable iff (rst)
    seeding |-> !rsp.valid && round <= ROUND_LAST)
    else $error("seeding produced a result or overran its rounds");

  a_seed_ends_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(seeding) |-> state == ST_IDLE)
    else $error("seeding finished outside idle");
`endif

endmodule
